FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Antecedent holds in a cycle: consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent holds in a cycle: consequent holds in the following cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/bgb_pkg.sv
// ----------------------------------------------------------------------------
// bgb_pkg
// Types, constants and helpers for the bitmap glyph blitter.
// ----------------------------------------------------------------------------
package bgb_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int GLYPH_ROWS      = 16;
    localparam int CELL_W          = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // register indexes (paddr[2])
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [7:0]         char_code;
        logic [3:0]         row_index;
        logic [7:0]         font_byte;
        logic signed [11:0] x_pos;
        logic signed [11:0] y_pos;
        logic [23:0]        fg_color;
        logic [23:0]        bg_color;
        logic               fill_background;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  write_mask;
        logic [7:0]  fg_select;
        logic [23:0] out_fg_color;
        logic [23:0] out_bg_color;
        logic        last_row;
    } t_out_item;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
    } t_cfg;

    // command handed from front to back: loads carry mirrored bits,
    // draws have already passed the fit test
    typedef struct packed {
        logic        kind;
        logic [7:0]  char_code;
        logic [3:0]  row_index;
        logic [7:0]  bits;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [23:0] fg_color;
        logic [23:0] bg_color;
        logic        fill;
    } t_cmd;

    typedef enum logic {
        BACK_IDLE,
        BACK_DRAW
    } t_back_state;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] t;
        t = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
        t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
        return t;
    endfunction

endpackage

FILE: rtl/bitmap_glyph_blitter.sv
// ----------------------------------------------------------------------------
// bitmap_glyph_blitter
// Font store and 8x16 character renderer with an APB register port.
// ----------------------------------------------------------------------------
// A drawn character goes through the queue, the back end's dispatch, the font
// RAM read and the row buffer; the back end dispatches it, then reads its rows
// one per font RAM read while the buffer has room. A load is written as it is popped.
// Loads and clipped draws give no result; a four-entry queue buffers items.
// Reset: synchronous, active low; clears control state and sets the screen to
// 640x480. The font RAM is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
module bitmap_glyph_blitter #(
    parameter int GLYPH_COUNT = bgb_pkg::GLYPH_COUNT_DEF,
    parameter int QUEUE_DEPTH = bgb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bgb_pkg::t_in_item  i_in_item,
    // row result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bgb_pkg::t_out_item o_out_item,
    // APB register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bgb_pkg::*;

    t_cfg r_cfg;
    t_cmd q_in_cmd, q_out_cmd;
    logic q_push, q_full, q_valid, q_pop;

    // Register file: width at 0x0, height at 0x4. Take a write on the access
    // phase; pready is tied high so no wait states are inserted.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= WIDTH_RESET;
            r_cfg.screen_height <= HEIGHT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_WIDTH:  r_cfg.screen_width  <= pwdata[11:0];
                REG_HEIGHT: r_cfg.screen_height <= pwdata[11:0];
                default:    r_cfg.screen_width  <= r_cfg.screen_width;
            endcase
        end
    end

    // Read back, zero extended to the bus width; low address bits are ignored.
    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {20'd0, r_cfg.screen_width};
            REG_HEIGHT: prdata = {20'd0, r_cfg.screen_height};
            default:    prdata = 32'd0;
        endcase
    end

    // Front: classify each transfer, mirror font bytes, clip draws.
    bgb_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    // Queue: decouple intake from rendering so each side stalls on its own.
    bgb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // Back: write the font RAM in order with draws, stream rows out through
    // a two-entry buffer that throttles reads against output stalls.
    bgb_back #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: rtl/bgb_ram.sv
// ----------------------------------------------------------------------------
// bgb_ram
// Generic simple dual-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bgb_queue.sv
// ----------------------------------------------------------------------------
// bgb_queue
// Small command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgb_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bgb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bgb_pkg::t_cmd o_cmd
);
    import bgb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push_ok) - CW'(pop_ok);
        end
    end

    `ASSERT_IMPLIES(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full)

endmodule

FILE: rtl/bgb_front.sv
// ----------------------------------------------------------------------------
// bgb_front
// Accepts input items, drops the ones that do nothing, queues the rest.
// ----------------------------------------------------------------------------
module bgb_front #(
    parameter int GLYPH_COUNT = 256
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bgb_pkg::t_in_item i_in_item,
    input  bgb_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_q_push,
    output bgb_pkg::t_cmd     o_q_cmd
);
    import bgb_pkg::*;

    localparam logic [8:0] CODE_LIMIT = 9'(GLYPH_COUNT);

    logic        accept, code_ok, fits;
    logic [12:0] x_end, y_end;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign code_ok    = ({1'b0, i_in_item.char_code} < CODE_LIMIT);

    // cell must lie wholly on screen
    assign x_end = {2'b00, i_in_item.x_pos[10:0]} + 13'(CELL_W);
    assign y_end = {2'b00, i_in_item.y_pos[10:0]} + 13'(GLYPH_ROWS);
    assign fits  = !i_in_item.x_pos[11] && !i_in_item.y_pos[11]
                && (x_end <= {1'b0, i_cfg.screen_width})
                && (y_end <= {1'b0, i_cfg.screen_height});

    always_comb begin
        o_q_push = 1'b0;
        if (accept && code_ok) begin
            unique case (i_in_item.kind)
                KIND_LOAD: o_q_push = 1'b1;
                KIND_DRAW: o_q_push = fits;
                default:   o_q_push = 1'b0;
            endcase
        end
    end

    always_comb begin
        o_q_cmd.kind      = i_in_item.kind;
        o_q_cmd.char_code = i_in_item.char_code;
        o_q_cmd.row_index = i_in_item.row_index;
        o_q_cmd.bits      = mirror8(i_in_item.font_byte);
        o_q_cmd.x_pos     = i_in_item.x_pos;
        o_q_cmd.y_pos     = i_in_item.y_pos;
        o_q_cmd.fg_color  = i_in_item.fg_color;
        o_q_cmd.bg_color  = i_in_item.bg_color;
        o_q_cmd.fill      = i_in_item.fill_background;
    end

endmodule

FILE: rtl/bgb_back.sv
// ----------------------------------------------------------------------------
// bgb_back
// Executes queued commands: font writes and sixteen-row glyph reads.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgb_back #(
    parameter int GLYPH_COUNT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  bgb_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bgb_pkg::t_out_item o_out_item
);
    import bgb_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic        fill;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        last;
    } t_meta;

    t_back_state r_state, n_state;
    t_cmd        r_cur;
    logic [3:0]  r_row;
    logic        r_inflight;
    t_meta       r_meta;
    t_out_item   r_buf [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    logic          we, issue, pop, push, take_cmd;
    logic [2:0]    occ, room;
    logic [11:0]   waddr_full, raddr_full;
    logic [7:0]    rdata;
    t_out_item     push_item;

    assign pop  = o_out_valid && i_out_ready;
    assign push = r_inflight;

    // rows in flight plus rows buffered must fit the two-entry buffer
    assign occ  = {1'b0, r_cnt} + {2'b00, r_inflight};
    assign room = 3'd1 + {2'b00, pop};

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        we       = 1'b0;
        issue    = 1'b0;
        take_cmd = 1'b0;
        unique case (r_state)
            BACK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.kind == KIND_LOAD) begin
                        we = 1'b1;
                    end else begin
                        take_cmd = 1'b1;
                        n_state  = BACK_DRAW;
                    end
                end
            end
            BACK_DRAW: begin
                if (occ <= room) begin
                    issue = 1'b1;
                    if (r_row == 4'(GLYPH_ROWS - 1)) begin
                        n_state = BACK_IDLE;
                    end
                end
            end
            default: n_state = BACK_IDLE;
        endcase
    end

    assign waddr_full = {i_q_cmd.char_code, i_q_cmd.row_index};
    assign raddr_full = {r_cur.char_code, r_row};

    bgb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr_full[AW-1:0]),
        .i_wdata (i_q_cmd.bits),
        .i_re    (issue),
        .i_raddr (raddr_full[AW-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BACK_IDLE;
            r_row      <= '0;
            r_inflight <= 1'b0;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_inflight <= issue;
            if (take_cmd) begin
                r_row <= '0;
            end else if (issue) begin
                r_row <= r_row + 1'b1;
            end
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_cmd) begin
            r_cur <= i_q_cmd;
        end
        if (issue) begin
            r_meta.x    <= r_cur.x_pos;
            r_meta.y    <= r_cur.y_pos + 12'(r_row);
            r_meta.fill <= r_cur.fill;
            r_meta.fg   <= r_cur.fg_color;
            r_meta.bg   <= r_cur.bg_color;
            r_meta.last <= (r_row == 4'(GLYPH_ROWS - 1));
        end
        if (push) begin
            r_buf[r_wp] <= push_item;
        end
    end

    always_comb begin
        push_item.pixel_x      = r_meta.x;
        push_item.pixel_y      = r_meta.y;
        push_item.write_mask   = r_meta.fill ? 8'hFF : rdata;
        push_item.fg_select    = rdata;
        push_item.out_fg_color = r_meta.fg;
        push_item.out_bg_color = r_meta.bg;
        push_item.last_row     = r_meta.last;
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_item  = r_buf[r_rp];

    `ASSERT_IMPLIES(a_buf_no_overflow, i_clk, i_rst_n, push, (r_cnt != 2'd2) || pop)
    `ASSERT_IMPLIES(a_write_only_idle, i_clk, i_rst_n, we, r_state == BACK_IDLE)
    `ASSERT_NEXT(a_last_row_ends, i_clk, i_rst_n, issue && (r_row == 4'(GLYPH_ROWS - 1)), (r_state == BACK_IDLE) && r_inflight)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap glyph blitter. Loads fonts, draws
// characters at many positions and screen sizes, and compares every row
// transfer against a predicted stream of rows.
// ----------------------------------------------------------------------------
module tb_top;
    import bgb_pkg::*;

    localparam int CLK_HALF     = 2;
    // four queued draws plus the rows still in the pipeline, with margin
    localparam int DRAIN_CYCLES = 120;
    localparam int STORE_ROWS   = 4096;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

    // Row bytes for the first eight rows of patterned glyphs, row 0 in the low byte.
    localparam logic [63:0] ROW_PATTERN = 64'h0F_F0_55_AA_01_80_FF_00;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    bitmap_glyph_blitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state: mirrored font image and the screen size it clips to
    // ------------------------------------------------------------------------
    logic [7:0]  font_img [STORE_ROWS];
    logic [11:0] cur_width  = WIDTH_RESET;
    logic [11:0] cur_height = HEIGHT_RESET;
    t_out_item   rows_due[$];

    // Stimulus bookkeeping. Draws only ever pick from fully loaded glyphs,
    // so the font RAM is never read before it holds real data.
    t_in_item    items_pending[$];
    int unsigned items_issued = 0;
    int unsigned items_taken  = 0;
    bit [15:0]   rows_loaded [256];
    bit          glyph_listed [256];
    int          ready_glyphs[$];

    int mismatches = 0;
    bit steady     = 1'b0;   // no idling on either side while set
    int send_gap   = 0;
    int hold_cnt   = 0;

    // ------------------------------------------------------------------------
    // Clock, and the hard stop should the run hang
    // ------------------------------------------------------------------------
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #LIMIT_NS;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Font rows are stored with the leftmost pixel in bit 0.
    function automatic logic [7:0] flip_row(input logic [7:0] raw);
        logic [7:0] res;
        for (int j = 0; j < CELL_W; j++) begin
            res[j] = raw[CELL_W - 1 - j];
        end
        return res;
    endfunction

    // Mostly back-to-back, some short gaps, now and then a long one.
    function automatic int pick_gap();
        int sel;
        if (steady) begin
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            return 0;
        end
        if (sel < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Fill every field with noise first so that ignored fields toggle too.
    function automatic t_in_item noise_item();
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        return noise[$bits(t_in_item)-1:0];
    endfunction

    function automatic t_in_item make_load(input int code, input int row,
                                           input logic [7:0] bits);
        t_in_item it;
        it           = noise_item();
        it.kind      = KIND_LOAD;
        it.char_code = code[7:0];
        it.row_index = row[3:0];
        it.font_byte = bits;
        return it;
    endfunction

    function automatic t_in_item make_draw(input int code, input logic signed [11:0] x,
                                           input logic signed [11:0] y);
        t_in_item it;
        it           = noise_item();
        it.kind      = KIND_DRAW;
        it.char_code = code[7:0];
        it.x_pos     = x;
        it.y_pos     = y;
        return it;
    endfunction

    // Predict the rows caused by one accepted transfer.
    task automatic apply_item(input t_in_item it);
        int        xs;
        int        ys;
        t_out_item row;
        if (it.kind == KIND_LOAD) begin
            font_img[{it.char_code, it.row_index}] = flip_row(it.font_byte);
            return;
        end
        xs = $signed(it.x_pos);
        ys = $signed(it.y_pos);
        // drop cells that do not fit entirely on the screen
        if (xs < 0 || ys < 0 || xs + CELL_W > int'(cur_width)
                || ys + GLYPH_ROWS > int'(cur_height)) begin
            return;
        end
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            row.pixel_x      = it.x_pos;
            row.pixel_y      = it.y_pos + 12'(r);
            row.fg_select    = font_img[{it.char_code, 4'(r)}];
            row.write_mask   = it.fill_background ? 8'hFF : row.fg_select;
            row.out_fg_color = it.fg_color;
            row.out_bg_color = it.bg_color;
            row.last_row     = (r == GLYPH_ROWS - 1);
            rows_due.push_back(row);
        end
    endtask

    task automatic check_row(input t_out_item got);
        t_out_item want;
        if (rows_due.size() == 0) begin
            flag_mismatch("row with nothing pending", got.pixel_y, '0);
            return;
        end
        want = rows_due.pop_front();
        if (got.pixel_x !== want.pixel_x)
            flag_mismatch("pixel_x", got.pixel_x, want.pixel_x);
        if (got.pixel_y !== want.pixel_y)
            flag_mismatch("pixel_y", got.pixel_y, want.pixel_y);
        if (got.write_mask !== want.write_mask)
            flag_mismatch("write_mask", got.write_mask, want.write_mask);
        if (got.fg_select !== want.fg_select)
            flag_mismatch("fg_select", got.fg_select, want.fg_select);
        if (got.out_fg_color !== want.out_fg_color)
            flag_mismatch("out_fg_color", got.out_fg_color, want.out_fg_color);
        if (got.out_bg_color !== want.out_bg_color)
            flag_mismatch("out_bg_color", got.out_bg_color, want.out_bg_color);
        if (got.last_row !== want.last_row)
            flag_mismatch("last_row", got.last_row, want.last_row);
    endtask

    // Hand an item to the driver and note which glyphs become drawable.
    task automatic queue_item(input t_in_item it);
        if (it.kind == KIND_LOAD) begin
            rows_loaded[it.char_code][it.row_index] = 1'b1;
            if (&rows_loaded[it.char_code] && !glyph_listed[it.char_code]) begin
                glyph_listed[it.char_code] = 1'b1;
                ready_glyphs.push_back(it.char_code);
            end
        end
        items_pending.push_back(it);
        items_issued++;
    endtask

    task automatic load_glyph(input int code, input bit patterned);
        logic [7:0] bits;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            bits = (patterned && r < 8) ? ROW_PATTERN[r*8 +: 8] : 8'($urandom);
            queue_item(make_load(code, r, bits));
        end
    endtask

    // Mostly cells that fit, some straddling the right or bottom edge, the
    // rest anywhere in the signed range (mostly clipped).
    task automatic pick_spot(output logic signed [11:0] x, output logic signed [11:0] y);
        int sel;
        int xmax;
        int ymax;
        xmax = int'(cur_width) - CELL_W;
        ymax = int'(cur_height) - GLYPH_ROWS;
        if (xmax > 2047) xmax = 2047;
        if (ymax > 2047) ymax = 2047;
        sel = $urandom_range(0, 99);
        if (sel < 70 && xmax >= 0 && ymax >= 0) begin
            x = 12'($urandom_range(0, xmax));
            y = 12'($urandom_range(0, ymax));
        end else if (sel < 85 && xmax >= 0 && ymax >= 0) begin
            x = 12'(xmax + $urandom_range(0, 1));
            y = 12'(ymax + $urandom_range(0, 1));
        end else begin
            x = 12'($urandom);
            y = 12'($urandom);
        end
    endtask

    task automatic random_items(input int count);
        int done;
        int sel;
        int code;
        logic signed [11:0] x;
        logic signed [11:0] y;
        done = 0;
        while (done < count) begin
            sel  = $urandom_range(0, 99);
            code = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
            if (sel < 60) begin
                pick_spot(x, y);
                queue_item(make_draw(code, x, y));
                done++;
            end else if (sel < 85) begin
                // rewrite one row of a drawable glyph
                queue_item(make_load(code, $urandom_range(0, 15), 8'($urandom)));
                done++;
            end else if (sel < 92) begin
                // stray row of any glyph; only drawn once the glyph is complete
                queue_item(make_load($urandom_range(0, 255), $urandom_range(0, 15),
                                     8'($urandom)));
                done++;
            end else begin
                load_glyph($urandom_range(0, 255), 1'b0);
                done += GLYPH_ROWS;
            end
        end
    endtask

    // Hold until every item has gone in and every row has come out, then
    // let loads still in the queue drain.
    task automatic wait_idle();
        while (items_taken != items_issued || rows_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [11:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WIDTH) begin
            cur_width = value;
        end else begin
            cur_height = value;
        end
    endtask

    task automatic reg_check(input logic [2:0] addr, input logic [11:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[11:0] !== want) begin
            flag_mismatch("screen register readback", prdata, want);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_screen(input logic [11:0] w, input logic [11:0] h);
        reg_write(ADDR_WIDTH, w);
        reg_write(ADDR_HEIGHT, h);
        reg_check(ADDR_WIDTH, w);
        reg_check(ADDR_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // Driver: present pending items, predict each one as its transfer lands
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                apply_item(i_in_item);
                items_taken++;
            end
            // advance only when nothing is waiting on the channel
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (items_pending.size() != 0) begin
                    i_in_item  <= items_pending.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap   <= pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each row transfer, stall the result side at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                check_row(o_out_item);
            end
            if (hold_cnt > 0) begin
                hold_cnt    <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                hold_cnt    <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_in_item it;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers come out of reset at 640x480
        reg_check(ADDR_WIDTH, WIDTH_RESET);
        reg_check(ADDR_HEIGHT, HEIGHT_RESET);

        // Load the lowest and highest glyph with edge patterns, one more at random.
        load_glyph(0, 1'b1);
        load_glyph(255, 1'b1);
        load_glyph($urandom_range(1, 254), 1'b0);

        // Transparent and background mode with extreme colours.
        it = make_draw(0, 0, 0);
        it.fill_background = 1'b0;
        it.fg_color        = 24'h000000;
        it.bg_color        = 24'hFFFFFF;
        queue_item(it);
        it = make_draw(255, 0, 0);
        it.fill_background = 1'b1;
        it.fg_color        = 24'hFFFFFF;
        it.bg_color        = 24'h000000;
        queue_item(it);

        // Exact fit at the bottom-right corner, then one pixel past each edge.
        queue_item(make_draw(255, 632, 464));
        queue_item(make_draw(255, 633, 464));
        queue_item(make_draw(255, 632, 465));

        // Negative positions and the far ends of the signed range.
        queue_item(make_draw(0, -1, 0));
        queue_item(make_draw(0, 0, -1));
        queue_item(make_draw(0, -2048, -2048));
        queue_item(make_draw(0, 2047, 2047));

        // Rewrite a row with noisy position fields, then draw it back.
        queue_item(make_load(0, 0, 8'h81));
        queue_item(make_draw(0, 100, 200));

        random_items(10);
        wait_idle();

        // Smallest legal screen: only the origin fits.
        set_screen(12'd8, 12'd16);
        queue_item(make_draw(255, 0, 0));
        queue_item(make_draw(255, 1, 0));
        queue_item(make_draw(255, 0, 1));
        random_items(5);
        wait_idle();

        // Largest screen: even the top of the signed range fits.
        set_screen(12'd4095, 12'd4095);
        queue_item(make_draw(0, 2047, 2047));
        queue_item(make_draw(255, 0, 0));
        random_items(5);
        wait_idle();

        // Below the stated bounds: nothing can fit, loads still land.
        set_screen(12'd7, 12'd15);
        queue_item(make_draw(0, 0, 0));
        random_items(3);
        wait_idle();

        // Random screen with both sides running flat out.
        set_screen(12'($urandom_range(8, 4095)), 12'($urandom_range(16, 4095)));
        steady = 1'b1;
        random_items(6);
        wait_idle();
        steady = 1'b0;

        // Random screen with idling back on.
        set_screen(12'($urandom_range(8, 4095)), 12'($urandom_range(16, 4095)));
        random_items(6);
        wait_idle();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
